FILE: rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and sizes for the sweep-and-prune axis pair generator.
// ----------------------------------------------------------------------------
package spa_pkg;

  // size of the active set and significant id bits
  localparam int unsigned MAX_ACTIVE = 32;
  localparam int unsigned ID_BITS    = 16;

  // fixed width of the id fields on the ports
  localparam int unsigned ENTITY_W = 16;

  // stored key width: significant id bits, capped by the port field
  localparam int unsigned KEY_W = (ID_BITS < ENTITY_W) ? ID_BITS : ENTITY_W;

  // scan step counter
  localparam int unsigned CNT_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;

  typedef logic [KEY_W-1:0] key_t;

  // input transaction
  typedef struct packed {
    logic [ENTITY_W-1:0] entity_id;
    logic                pass_start;
  } spa_in_t;

  // output transaction
  typedef struct packed {
    logic [ENTITY_W-1:0] id_low;
    logic [ENTITY_W-1:0] id_high;
    logic                overflow;
    logic                last;
  } spa_out_t;

  // contents of one slot of the active set
  typedef struct packed {
    logic valid;
    logic pend;
    key_t id;
  } spa_slot_t;

  // broadcast control from the sequencer to all cells
  typedef struct packed {
    logic accept;
    logic clr;
    logic arm;
    logic rotate;
    key_t key;
  } spa_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OVF  = 3'b100
  } spa_state_e;

endpackage

FILE: rtl/sweep_prune_axis_pairs.sv
// ----------------------------------------------------------------------------
// sweep_prune_axis_pairs
// One-axis sweep-and-prune pair generator built as a ring of slot cells.
// ----------------------------------------------------------------------------
// a removal or an insert into an empty set is written straight into the cells;
//   an overflow result is loaded into the output register from the OVF state;
//   the pairs appear in slot order as the ring turns, held by output stalls
// an insert into a non-empty set holds the input for one full turn of the
//   cell ring, which waits while the output register is stalled
// reset: asynchronous, clears the active set, the sequencer and output valid
module sweep_prune_axis_pairs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spa_pkg::spa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spa_pkg::spa_out_t out_data_o
);
  import spa_pkg::*;

  // sequencer
  spa_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  key_t cur_id_q, cur_id_d;

  // output register
  logic     out_valid_q, out_valid_d;
  spa_out_t out_q, out_d;

  // cell ring
  spa_ctrl_t              ctrl;
  spa_slot_t [MAX_ACTIVE-1:0] slot;
  spa_slot_t [MAX_ACTIVE-1:0] nxt;
  logic [MAX_ACTIVE-1:0]  hit;
  logic [MAX_ACTIVE-1:0]  valid_eff;
  logic [MAX_ACTIVE-1:0]  free_vec;
  logic [MAX_ACTIVE-1:0]  free_oh;
  logic [MAX_ACTIVE-1:0]  pend_vec;
  logic [MAX_ACTIVE-1:0]  wr;

  logic in_acc;
  logic any_hit;
  logic full;
  logic ins;
  logic out_free;
  logic step;
  logic emit;
  logic last_pair;
  key_t key;

  assign key        = in_data_i.entity_id[KEY_W-1:0];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // set status as seen by this transaction, after an optional pass clear
  always_comb begin
    for (int i = 0; i < MAX_ACTIVE; i++) begin
      valid_eff[i] = slot[i].valid & ~in_data_i.pass_start;
      pend_vec[i]  = slot[i].pend;
    end
  end

  assign any_hit  = |hit;
  assign full     = &valid_eff;
  assign free_vec = ~valid_eff;
  // lowest free slot as one-hot
  assign free_oh  = free_vec & (~free_vec + MAX_ACTIVE'(1));
  assign ins      = in_acc && !any_hit && !full;
  assign wr       = ins ? free_oh : '0;

  // output slot can take a new transaction this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // ring turns one place per cycle while scanning; it waits when the slot at
  // the head has a pair to give and the output register is blocked
  assign step      = (state_q == ST_SCAN) && (!slot[0].pend || out_free);
  assign emit      = step && slot[0].pend;
  assign last_pair = ~|pend_vec[MAX_ACTIVE-1:1];

  always_comb begin
    ctrl.accept = in_acc;
    ctrl.clr    = in_data_i.pass_start;
    ctrl.arm    = ins;
    ctrl.rotate = step;
    ctrl.key    = key;
  end

  // neighbor wiring: head wraps to the tail with its pending bit spent
  always_comb begin
    for (int i = 0; i < MAX_ACTIVE - 1; i++) begin
      nxt[i] = slot[i+1];
    end
    nxt[MAX_ACTIVE-1]      = slot[0];
    nxt[MAX_ACTIVE-1].pend = 1'b0;
  end

  for (genvar g = 0; g < MAX_ACTIVE; g++) begin : g_cell
    spa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .wr_i   (wr[g]),
      .rm_i   (hit[g]),
      .nxt_i  (nxt[g]),
      .slot_o (slot[g]),
      .hit_o  (hit[g])
    );
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cur_id_d = cur_id_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !any_hit) begin
          if (full) begin
            state_d = ST_OVF;
          end else if (|valid_eff) begin
            // pairs to give: one full turn of the ring
            state_d  = ST_SCAN;
            cnt_d    = '0;
            cur_id_d = key;
          end
        end
      end
      ST_SCAN: begin
        if (step) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(MAX_ACTIVE - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OVF: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.overflow   = 1'b0;
      out_d.last       = last_pair;
      // order the pair by id value
      if (slot[0].id > cur_id_q) begin
        out_d.id_low  = ENTITY_W'(cur_id_q);
        out_d.id_high = ENTITY_W'(slot[0].id);
      end else begin
        out_d.id_low  = ENTITY_W'(slot[0].id);
        out_d.id_high = ENTITY_W'(cur_id_q);
      end
    end else if ((state_q == ST_OVF) && out_free) begin
      out_valid_d    = 1'b1;
      out_d.id_low   = '0;
      out_d.id_high  = '0;
      out_d.overflow = 1'b1;
      out_d.last     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_id_q <= cur_id_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/spa_cell.sv
// ----------------------------------------------------------------------------
// spa_cell
// One slot of the active set: holds an id with its valid and pending bits,
// compares against the incoming key and shifts to its neighbor on rotate.
// ----------------------------------------------------------------------------
module spa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spa_pkg::spa_ctrl_t ctrl_i,
  input  logic               wr_i,
  input  logic               rm_i,
  input  spa_pkg::spa_slot_t nxt_i,
  output spa_pkg::spa_slot_t slot_o,
  output logic               hit_o
);
  import spa_pkg::*;

  logic valid_q, valid_d;
  logic pend_q, pend_d;
  key_t id_q, id_d;
  logic valid_eff;

  // pass start hides all entries of the old pass
  assign valid_eff = valid_q & ~ctrl_i.clr;
  assign hit_o     = valid_eff && (id_q == ctrl_i.key);

  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    id_d    = id_q;
    if (ctrl_i.rotate) begin
      valid_d = nxt_i.valid;
      pend_d  = nxt_i.pend;
      id_d    = nxt_i.id;
    end else if (ctrl_i.accept) begin
      valid_d = wr_i | (valid_eff & ~rm_i);
      pend_d  = ctrl_i.arm & valid_eff;
      if (wr_i) begin
        id_d = ctrl_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.pend  = pend_q;
  assign slot_o.id    = id_q;

endmodule
